// ----- rtl/utf8cc_pkg.sv -----
// Package: shared types, constants and decode functions for the UTF-8 character counter.
`timescale 1ns / 1ps

package utf8cc_pkg;

  localparam int MaxTextBytes = 65536;
  localparam int CountW       = 17;
  localparam int CountMaxInt  = (1 << CountW) - 1;
  localparam int CountCapInt  = (MaxTextBytes < CountMaxInt) ? MaxTextBytes : CountMaxInt;
  localparam logic [CountW-1:0] CountCap = CountCapInt[CountW-1:0];

  localparam int QueueDepth = 4;
  localparam int QueueCntW  = 3;

  localparam logic [7:0] AsciiMask = 8'h80;
  localparam logic [7:0] Lead2Mask = 8'he0;
  localparam logic [7:0] Lead2Code = 8'hc0;
  localparam logic [7:0] Lead3Mask = 8'hf0;
  localparam logic [7:0] Lead3Code = 8'he0;
  localparam logic [7:0] Lead4Mask = 8'hf8;
  localparam logic [7:0] Lead4Code = 8'hf0;
  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContCode  = 8'h80;

  typedef enum logic [0:0] {
    StIdle,
    StScan
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic step;
    logic finish_last;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic incomplete;
    logic last;
    logic out_free;
  } dp_status_t;

  function automatic logic [2:0] lead_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if ((b & AsciiMask) == 8'h00) begin
      len = 3'd1;
    end else if ((b & Lead2Mask) == Lead2Code) begin
      len = 3'd2;
    end else if ((b & Lead3Mask) == Lead3Code) begin
      len = 3'd3;
    end else if ((b & Lead4Mask) == Lead4Code) begin
      len = 3'd4;
    end
    return len;
  endfunction

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
    logic [CountW-1:0] r;
    r = c;
    if (c < CountCap) begin
      r = c + {{(CountW-1){1'b0}}, 1'b1};
    end
    return r;
  endfunction

endpackage

// ----- rtl/utf8cc_ctrl.sv -----
// Controller: sequences loading of one byte and the scan of held leads.
`timescale 1ns / 1ps

module utf8cc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  utf8cc_pkg::dp_status_t status_i,
  output utf8cc_pkg::dp_cmd_t    cmd_o
);
  import utf8cc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          state_d = StScan;
        end
      end
      StScan: begin
        if (status_i.empty || status_i.incomplete) begin
          if (!status_i.last || status_i.out_free) begin
            state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      StScan: begin
        if (status_i.empty || status_i.incomplete) begin
          cmd_o.finish_last = status_i.last && status_i.out_free;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

// ----- rtl/utf8cc_dp.sv -----
// Datapath: byte queue, lead decode, running count and result register.
`timescale 1ns / 1ps

module utf8cc_dp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [7:0]                      text_byte_i,
  input  logic                            last_byte_i,
  input  utf8cc_pkg::dp_cmd_t             cmd_i,
  output utf8cc_pkg::dp_status_t          status_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [utf8cc_pkg::CountW-1:0]   char_count_o
);
  import utf8cc_pkg::*;

  logic [7:0]           queue_q [QueueDepth];
  logic [7:0]           queue_d [QueueDepth];
  logic [QueueCntW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0]    count_q, count_d;
  logic                 last_q, last_d;
  logic                 out_valid_q, out_valid_d;
  logic [CountW-1:0]    out_count_q, out_count_d;

  logic [2:0]           len;
  logic [QueueDepth-1:1] cont;
  logic                 seq_ok;
  logic [QueueCntW-1:0] adv;

  assign len = lead_len(queue_q[0]);

  always_comb begin
    for (int i = 1; i < QueueDepth; i++) begin
      cont[i] = (queue_q[i] & ContMask) == ContCode;
    end
  end

  always_comb begin
    case (len)
      3'd2:    seq_ok = cont[1];
      3'd3:    seq_ok = cont[1] & cont[2];
      3'd4:    seq_ok = cont[1] & cont[2] & cont[3];
      default: seq_ok = 1'b0;
    endcase
  end

  assign adv = seq_ok ? len : 3'd1;

  assign status_o.empty      = (cnt_q == '0);
  assign status_o.incomplete = (cnt_q != '0) && (len > 3'd1) && (cnt_q < len);
  assign status_o.last       = last_q;
  assign status_o.out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    queue_d     = queue_q;
    cnt_d       = cnt_q;
    count_d     = count_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_count_d = out_count_q;
    if (cmd_i.load) begin
      queue_d[cnt_q[1:0]] = text_byte_i;
      cnt_d               = cnt_q + 3'd1;
      last_d              = last_byte_i;
    end else if (cmd_i.step) begin
      for (int i = 0; i < QueueDepth; i++) begin
        if (i + int'(adv) < QueueDepth) begin
          queue_d[i] = queue_q[i + int'(adv)];
        end
      end
      cnt_d   = cnt_q - adv;
      count_d = sat_inc(count_q);
    end else if (cmd_i.finish_last) begin
      out_valid_d = 1'b1;
      out_count_d = status_o.incomplete ? sat_inc(count_q) : count_q;
      cnt_d       = '0;
      count_d     = '0;
      last_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      count_q     <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      count_q     <= count_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    queue_q     <= queue_d;
    out_count_q <= out_count_d;
  end

  assign out_valid_o  = out_valid_q;
  assign char_count_o = out_count_q;

endmodule

// ----- rtl/utf8_character_counter.sv -----
// Top level: UTF-8 character counter with controller and datapath.
//
// Channel  Direction  Handshake               Payload
// in       input      in_valid_i/in_stall_o    text_byte_i, last_byte_i
// out      output     out_valid_o/out_stall_i  char_count_o
//
// Each byte is loaded, then the held leads are examined (up to four of them, one
// lead per cycle through the decode unit), then the scan closes.
// The closing cycle of a final byte waits while an earlier result is stalled.
// Reset clears the count, the queue fill and the result valid.
// A result stays in its register until taken; loading of the next text goes on.
`timescale 1ns / 1ps

module utf8_character_counter (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    text_byte_i,
  input  logic                          last_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [utf8cc_pkg::CountW-1:0] char_count_o
);
  import utf8cc_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  utf8cc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  utf8cc_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_byte_i  (text_byte_i),
    .last_byte_i  (last_byte_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_count_o (char_count_o)
  );

`ifndef ASSERT_OFF
  a_count_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (char_count_o != '0) && (char_count_o <= CountCap))
    else $error("result count out of range");

  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not held off after a transaction");

  a_one_command : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.step, cmd.finish_last}))
    else $error("conflicting datapath commands");
`endif

endmodule

// ----- sim/utf8_character_counter_tb.sv -----
// Testbench for the UTF-8 character counter: directed and random texts checked against a predictor.
`timescale 1ns / 1ps

module utf8_character_counter_tb;
  import utf8cc_pkg::*;

  localparam int RandomBytes  = 400;
  localparam int HoldOffLen   = 300;
  localparam int DrainCycles  = 20;

  class count_scoreboard;
    logic [7:0]        held[3];
    int unsigned       held_n;
    logic [CountW-1:0] running;
    logic [CountW-1:0] expected_counts[$];
    int unsigned       errors;
    int unsigned       checked;

    function new();
      held_n  = 0;
      running = '0;
      errors  = 0;
      checked = 0;
    endfunction

    function int unsigned seq_length(logic [7:0] b);
      casez (b)
        8'b0???????: return 1;
        8'b110?????: return 2;
        8'b1110????: return 3;
        8'b11110???: return 4;
        default:     return 0;
      endcase
    endfunction

    function void bump();
      if (running < CountCap) begin
        running = running + 1'b1;
      end
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [7:0]  q[4];
      int unsigned n;
      int unsigned pos;
      int unsigned len;
      int unsigned i;
      bit          ok;
      for (i = 0; i < held_n; i++) begin
        q[i] = held[i];
      end
      q[held_n] = b;
      n   = held_n + 1;
      pos = 0;
      while (pos < n) begin
        len = seq_length(q[pos]);
        if (len <= 1) begin
          bump();
          pos++;
        end else if (n - pos < len) begin
          if (last) begin
            bump();
            pos = n;
          end else begin
            break;
          end
        end else begin
          ok = 1'b1;
          for (i = 1; i < len; i++) begin
            if (q[pos + i][7:6] != 2'b10) begin
              ok = 1'b0;
            end
          end
          bump();
          pos += ok ? len : 1;
        end
      end
      held_n = 0;
      for (i = pos; i < n && held_n < 3; i++) begin
        held[held_n] = q[i];
        held_n++;
      end
      if (last) begin
        expected_counts.insert(expected_counts.size(), running);
        running = '0;
        held_n  = 0;
      end
    endfunction

    function void check_count(logic [CountW-1:0] got);
      logic [CountW-1:0] want;
      checked++;
      if (expected_counts.size() == 0) begin
        $error("char_count: unexpected result, actual %0d", got);
        errors++;
      end else begin
        want = expected_counts.pop_front();
        if (got !== want) begin
          $error("char_count mismatch: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function void report_leftovers();
      if (expected_counts.size() != 0) begin
        $error("char_count: %0d expected results never arrived", expected_counts.size());
        errors++;
      end
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic [7:0]          text_byte_i = 8'h00;
  logic                last_byte_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [CountW-1:0]   char_count_o;

  count_scoreboard board;
  logic [7:0]      text_q[$];
  bit              idle_on  = 1'b1;
  bit              hold_off = 1'b0;
  int unsigned     bytes_sent;
  int unsigned     texts_sent;

  utf8_character_counter dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .text_byte_i (text_byte_i),
    .last_byte_i (last_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_count_o(char_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (idle_on && $urandom_range(99) < 32) begin
      gap = $urandom_range(1, 3);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_text();
    int unsigned i;
    for (i = 0; i < text_q.size(); i++) begin
      send_byte(text_q[i], i == text_q.size() - 1);
    end
    texts_sent++;
  endtask

  function automatic logic [7:0] lead_of(int unsigned len);
    logic [7:0] r;
    r = 8'($urandom);
    case (len)
      1:       r = {1'b0, r[6:0]};
      2:       r = {3'b110, r[4:0]};
      3:       r = {4'b1110, r[3:0]};
      default: r = {5'b11110, r[2:0]};
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cont_byte();
    logic [7:0] r;
    r = 8'($urandom);
    return {2'b10, r[5:0]};
  endfunction

  function automatic logic [7:0] non_cont_byte();
    logic [7:0] r;
    r = 8'($urandom);
    if (r[7:6] == 2'b10) begin
      r[6] = 1'b1;
    end
    return r;
  endfunction

  task automatic append_char();
    int unsigned kind;
    int unsigned len;
    int unsigned conts;
    int unsigned i;
    kind = $urandom_range(99);
    if (kind < 65) begin
      len = $urandom_range(1, 4);
      text_q.insert(text_q.size(), lead_of(len));
      for (i = 1; i < len; i++) begin
        text_q.insert(text_q.size(), cont_byte());
      end
    end else if (kind < 80) begin
      text_q.insert(text_q.size(), 8'($urandom));
    end else if (kind < 90) begin
      len   = $urandom_range(2, 4);
      conts = $urandom_range(0, len - 2);
      text_q.insert(text_q.size(), lead_of(len));
      for (i = 0; i < conts; i++) begin
        text_q.insert(text_q.size(), cont_byte());
      end
    end else begin
      len   = $urandom_range(2, 4);
      conts = $urandom_range(0, len - 2);
      text_q.insert(text_q.size(), lead_of(len));
      for (i = 0; i < conts; i++) begin
        text_q.insert(text_q.size(), cont_byte());
      end
      text_q.insert(text_q.size(), non_cont_byte());
    end
  endtask

  initial begin
    board = new();
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        board.check_count(char_count_o);
      end
      out_stall_i <= hold_off || (idle_on && ($urandom_range(99) < 32));
    end
  end

  initial begin
    wait (rst_ni);
    while (board.checked < 8) @(negedge clk_i);
    hold_off = 1'b1;
    repeat (HoldOffLen) @(negedge clk_i);
    hold_off = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned i;
    int unsigned random_bytes;
    int unsigned chars;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    text_q = '{8'h00};
    send_text();
    text_q = '{8'h7f, 8'hff, 8'h80, 8'hf8};
    send_text();
    text_q = '{8'hc3, 8'ha9, 8'he2, 8'h82, 8'hac, 8'hf0, 8'h9f, 8'h98, 8'h80};
    send_text();
    text_q = '{8'he2, 8'h41, 8'h82, 8'hc3};
    send_text();
    text_q = '{8'hf0, 8'h9f, 8'h98, 8'hc3, 8'ha9, 8'he2};
    send_text();

    random_bytes = 0;
    while (random_bytes < RandomBytes) begin
      text_q.delete();
      chars = $urandom_range(1, 6);
      for (i = 0; i < chars; i++) begin
        append_char();
      end
      idle_on = !(texts_sent >= 20 && texts_sent < 30);
      random_bytes += text_q.size();
      send_text();
    end
    idle_on = 1'b1;
    in_valid_i <= 1'b0;

    while (board.expected_counts.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    board.report_leftovers();

    $display("Run covered %0d texts, %0d bytes, %0d counts checked,", texts_sent, bytes_sent,
             board.checked);
    $display("with valid, stray, truncated and broken sequences and a long output hold-off.");
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/utf8cc_pkg.sv
rtl/utf8cc_ctrl.sv
rtl/utf8cc_dp.sv
rtl/utf8_character_counter.sv
sim/utf8_character_counter_tb.sv
